// ----- hw/rtl/brl_pkg.sv -----
package brl_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned SCR_BITS       = 13;
  localparam int unsigned CFG_DATA_BITS  = 32;
  localparam int unsigned CFG_ADDR_BITS  = 3;
  localparam int unsigned COLOR_BITS     = 32;

  localparam logic [SCR_BITS-1:0] SCR_WIDTH_RST  = 13'd800;
  localparam logic [SCR_BITS-1:0] SCR_HEIGHT_RST = 13'd600;

  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_type_t;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic [SCR_BITS-1:0] width;
    logic [SCR_BITS-1:0] height;
  } screen_cfg_t;

endpackage

// ----- hw/rtl/brl_cfg_regs.sv -----
module brl_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [brl_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [brl_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [brl_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                              cfg_pready,
  output brl_pkg::screen_cfg_t              scr_cfg
);
  import brl_pkg::*;

  logic [SCR_BITS-1:0] width_r;
  logic [SCR_BITS-1:0] height_r;
  reg_sel_t            sel;
  logic                wr_en;

  assign sel        = reg_sel_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SCR_WIDTH_RST;
      height_r <= SCR_HEIGHT_RST;
    end else if (wr_en) begin
      case (sel)
        REG_SCREEN_WIDTH:  width_r  <= cfg_pwdata[SCR_BITS-1:0];
        REG_SCREEN_HEIGHT: height_r <= cfg_pwdata[SCR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_SCREEN_WIDTH:  cfg_prdata = CFG_DATA_BITS'(width_r);
      REG_SCREEN_HEIGHT: cfg_prdata = CFG_DATA_BITS'(height_r);
      default:           cfg_prdata = '0;
    endcase
  end

  assign scr_cfg.width  = width_r;
  assign scr_cfg.height = height_r;

endmodule

// ----- hw/rtl/brl_core.sv -----
module brl_core #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  brl_pkg::req_type_t                  req,
  input  logic signed [COORD_BITS-1:0]        x0,
  input  logic signed [COORD_BITS-1:0]        y0,
  input  logic signed [COORD_BITS-1:0]        x1,
  input  logic signed [COORD_BITS-1:0]        y1,
  input  logic [brl_pkg::COLOR_BITS-1:0]      color,
  input  brl_pkg::screen_cfg_t                scr_cfg,
  output logic signed [COORD_BITS-1:0]        px,
  output logic signed [COORD_BITS-1:0]        py,
  output logic [brl_pkg::COLOR_BITS-1:0]      pcolor,
  output logic                                pwe,
  output logic                                plast
);
  import brl_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned DW = C + 1;
  localparam int unsigned EW = C + 3;
  localparam int unsigned CW = ((C > SCR_BITS) ? C : SCR_BITS) + 1;

  // line state
  logic signed [C-1:0]  cur_x_r, cur_x_nxt;
  logic signed [C-1:0]  cur_y_r, cur_y_nxt;
  logic signed [C-1:0]  major_end_r, major_end_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic signed [EW-1:0] inc_str_r, inc_str_nxt;
  logic signed [EW-1:0] inc_diag_r, inc_diag_nxt;
  logic                 steep_r, steep_nxt;
  logic                 up_r, up_nxt;
  logic                 active_r, active_nxt;
  logic [COLOR_BITS-1:0] color_r, color_nxt;

  function automatic logic below(input logic signed [C-1:0] v,
                                 input logic [SCR_BITS-1:0] lim);
    below = $signed({{(CW-C){v[C-1]}}, v}) < $signed({{(CW-SCR_BITS){1'b0}}, lim});
  endfunction

  function automatic logic visible(input logic signed [C-1:0] x,
                                   input logic signed [C-1:0] y,
                                   input screen_cfg_t s);
    visible = !x[C-1] && below(x, s.width) && !y[C-1] && below(y, s.height);
  endfunction

  // start path
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        adx, ady;
  logic                 s_steep, s_up, s_reject, s_last;
  logic [C-1:0]         amaj, amin;
  logic signed [C-1:0]  s_x, s_y, s_end;

  assign dx = $signed({x1[C-1], x1}) - $signed({x0[C-1], x0});
  assign dy = $signed({y1[C-1], y1}) - $signed({y0[C-1], y0});
  assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign s_steep = ady > adx;
  assign s_up = (dx[DW-1] && dy[DW-1]) ||
                (!dx[DW-1] && (dx != '0) && !dy[DW-1] && (dy != '0));
  assign s_reject = (x0[C-1] && x1[C-1]) || (y0[C-1] && y1[C-1]) ||
                    (!below(x0, scr_cfg.width) && !below(x1, scr_cfg.width)) ||
                    (!below(y0, scr_cfg.height) && !below(y1, scr_cfg.height));
  assign amaj = s_steep ? ady[C-1:0] : adx[C-1:0];
  assign amin = s_steep ? adx[C-1:0] : ady[C-1:0];

  always_comb begin
    if (s_steep ? !dy[DW-1] : !dx[DW-1]) begin
      s_x   = x0;
      s_y   = y0;
      s_end = s_steep ? y1 : x1;
    end else begin
      s_x   = x1;
      s_y   = y1;
      s_end = s_steep ? y0 : x0;
    end
  end

  assign s_last = s_steep ? (s_y >= s_end) : (s_x >= s_end);

  // advance path
  logic signed [C-1:0]  a_maj, a_min_cur, a_min;
  logic                 a_move, a_last;

  assign a_move    = steep_r ? (!err_r[EW-1] && (err_r != '0)) : !err_r[EW-1];
  assign a_maj     = (steep_r ? cur_y_r : cur_x_r) + C'(1);
  assign a_min_cur = steep_r ? cur_x_r : cur_y_r;
  assign a_min     = !a_move ? a_min_cur :
                     (up_r ? a_min_cur + C'(1) : a_min_cur - C'(1));
  assign a_last    = a_maj >= major_end_r;

  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    major_end_nxt = major_end_r;
    err_nxt       = err_r;
    inc_str_nxt   = inc_str_r;
    inc_diag_nxt  = inc_diag_r;
    steep_nxt     = steep_r;
    up_nxt        = up_r;
    active_nxt    = active_r;
    color_nxt     = color_r;
    px            = cur_x_r;
    py            = cur_y_r;
    pcolor        = color_r;
    pwe           = 1'b0;
    plast         = 1'b1;
    case (req)
      REQ_START: begin
        if (s_reject) begin
          active_nxt = 1'b0;
          px         = x0;
          py         = y0;
          pcolor     = color;
        end else begin
          cur_x_nxt     = s_x;
          cur_y_nxt     = s_y;
          major_end_nxt = s_end;
          err_nxt       = $signed({2'b00, amin, 1'b0}) - $signed({3'b000, amaj});
          inc_str_nxt   = $signed({2'b00, amin, 1'b0});
          inc_diag_nxt  = $signed({2'b00, amin, 1'b0}) - $signed({2'b00, amaj, 1'b0});
          steep_nxt     = s_steep;
          up_nxt        = s_up;
          active_nxt    = !s_last;
          color_nxt     = color;
          px            = s_x;
          py            = s_y;
          pcolor        = color;
          pwe           = visible(s_x, s_y, scr_cfg);
          plast         = s_last;
        end
      end
      REQ_ADVANCE: begin
        if (active_r) begin
          cur_x_nxt  = steep_r ? a_min : a_maj;
          cur_y_nxt  = steep_r ? a_maj : a_min;
          err_nxt    = err_r + (a_move ? inc_diag_r : inc_str_r);
          active_nxt = !a_last;
          px         = cur_x_nxt;
          py         = cur_y_nxt;
          pwe        = visible(cur_x_nxt, cur_y_nxt, scr_cfg);
          plast      = a_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      color_r  <= '0;
      active_r <= 1'b0;
    end else if (step) begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      color_r  <= color_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      major_end_r <= major_end_nxt;
      err_r       <= err_nxt;
      inc_str_r   <= inc_str_nxt;
      inc_diag_r  <= inc_diag_nxt;
      steep_r     <= steep_nxt;
      up_r        <= up_nxt;
    end
  end

endmodule

// ----- hw/rtl/bresenham_line_raster.sv -----
// Bresenham line rasterizer with per-pixel screen clipping.
// Input channel (in_*): in_tuser selects the request, 0 starts a line from
// the endpoints and color in in_tdata, 1 advances one pixel along the line.
// Every accepted request produces exactly one output transfer (out_*):
// pixel x, y and color in out_tdata, write enable in out_tuser (pixel lies
// on screen), and out_tlast on the final pixel of a line, on a rejected
// line, or on an advance with no line in progress.
// Screen width and height are set through the APB port (registers at byte
// addresses 0 and 4). The user must write them only while the engine is idle;
// the block itself does not enforce this. An input transfer passes the input
// register, then the step logic (one add and compare) into the output register.
// Throughput is one pixel per cycle while out_tready is high, set by one step.
// A stalled receiver holds the output register; the input register still
// takes one more transfer, then in_tready drops until out_tready returns.
// Synchronous reset empties both registers, drops any line in progress and
// restores the screen size to 800 by 600.
module bresenham_line_raster #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF,
  localparam int unsigned IN_DW  = ((4 * COORD_BITS + brl_pkg::COLOR_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_DW = ((2 * COORD_BITS + brl_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // start_x, start_y, end_x, end_y, pen_color
  input  logic [IN_DW-1:0]                  in_tdata,
  // req_type
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pixel_x, pixel_y, pixel_color
  output logic [OUT_DW-1:0]                 out_tdata,
  // write_enable
  output logic                              out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [brl_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [brl_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [brl_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                              cfg_pready
);
  import brl_pkg::*;

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned PLW = 4 * C + COLOR_BITS;

  screen_cfg_t scr_cfg;

  logic            in_valid_r;
  req_type_t       in_req_r;
  logic [PLW-1:0]  in_data_r;

  logic                   out_valid_r;
  logic signed [C-1:0]    out_x_r;
  logic signed [C-1:0]    out_y_r;
  logic [COLOR_BITS-1:0]  out_color_r;
  logic                   out_we_r;
  logic                   out_last_r;

  logic                   out_load;
  logic                   consume;
  logic signed [C-1:0]    px, py;
  logic [COLOR_BITS-1:0]  pcolor;
  logic                   pwe, plast;

  brl_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .scr_cfg     (scr_cfg)
  );

  assign out_load  = !out_valid_r || out_tready;
  assign consume   = in_valid_r && out_load;
  assign in_tready = rst_n && (!in_valid_r || consume);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_req_r  <= req_type_t'(in_tuser);
      in_data_r <= in_tdata[PLW-1:0];
    end
  end

  brl_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (consume),
    .req     (in_req_r),
    .x0      ($signed(in_data_r[C-1:0])),
    .y0      ($signed(in_data_r[2*C-1:C])),
    .x1      ($signed(in_data_r[3*C-1:2*C])),
    .y1      ($signed(in_data_r[4*C-1:3*C])),
    .color   (in_data_r[PLW-1:4*C]),
    .scr_cfg (scr_cfg),
    .px      (px),
    .py      (py),
    .pcolor  (pcolor),
    .pwe     (pwe),
    .plast   (plast)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      out_x_r     <= px;
      out_y_r     <= py;
      out_color_r <= pcolor;
      out_we_r    <= pwe;
      out_last_r  <= plast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({out_color_r, out_y_r, out_x_r});
  assign out_tuser  = out_we_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- hw/rtl/brl_checker.sv -----
module brl_checker #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF,
  localparam int unsigned OUT_DW = ((2 * COORD_BITS + brl_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [OUT_DW-1:0]                 out_tdata,
  input logic                              out_tuser,
  input logic                              out_tlast
);

  localparam int unsigned C = COORD_BITS;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("output transfer changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_we_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[C-1] && !out_tdata[2*C-1])
    else $error("write enable on negative coordinate");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("output appeared without input transfer two cycles earlier");

endmodule

bind bresenham_line_raster brl_checker #(.COORD_BITS(COORD_BITS)) u_brl_checker (.*);
